// ===== hw/rtl/skw_pkg.sv =====
// shared types and constants for the skinning weight top-k normalizer
// no dependencies

package skw_pkg;

    localparam int JOINT_W      = 8;
    localparam int WEIGHT_W     = 17;
    localparam int DEF_KEEP     = 4;
    localparam int DEF_FRAC     = 16;
    localparam logic [WEIGHT_W-1:0] MIN_WEIGHT_RST = WEIGHT_W'(1);

    typedef struct packed {
        logic [JOINT_W-1:0]  joint_index;
        logic [WEIGHT_W-1:0] joint_weight;
        logic                last_influence;
        logic                no_influence;
    } t_in_req;

    typedef struct packed {
        logic [JOINT_W-1:0]  out_joint;
        logic [WEIGHT_W-1:0] out_weight;
        logic                last_of_run;
    } t_out_req;

    typedef struct packed {
        logic                valid;
        logic [JOINT_W-1:0]  joint;
        logic [WEIGHT_W-1:0] weight;
    } t_slot;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/skw_cell.sv =====
// one ranked slot of the insertion chain
// depends on skw_pkg

module skw_cell
    import skw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_new,
    input  logic      i_prev_ins,
    input  t_slot     i_prev,
    input  t_slot     i_next,
    output logic      o_ins,
    output t_slot     o_slot
);

    t_slot r_slot;

    // strict compare keeps the earlier arrival ahead on a tie
    assign o_ins  = !r_slot.valid || (i_new.weight > r_slot.weight);
    assign o_slot = r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_slot.valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_slot <= i_next;
        end else if (i_ctl.insert && o_ins) begin
            r_slot <= i_prev_ins ? i_prev : i_new;
        end
    end

endmodule

// ===== hw/rtl/skw_div.sv =====
// serial restoring divider, one quotient bit per cycle
// computes floor(dividend * 2^FRAC_BITS / divisor) for dividend <= divisor
// depends on skw_pkg

module skw_div
    import skw_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC,
    parameter int SUM_W     = WEIGHT_W + 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WEIGHT_W-1:0] i_dividend,
    input  logic [SUM_W-1:0]    i_divisor,
    output logic                o_done,
    output logic [FRAC_BITS:0]  o_quot
);

    localparam int R_W   = SUM_W + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [R_W-1:0]     r_rem;
    logic [SUM_W-1:0]   r_den;
    logic [FRAC_BITS:0] r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic               q_bit;
    logic [R_W-1:0]     n_rem;

    assign q_bit = r_rem >= R_W'(r_den);
    assign n_rem = q_bit ? (r_rem - R_W'(r_den)) : r_rem;

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS + 1);
                r_rem  <= R_W'(i_dividend);
                r_den  <= i_divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem << 1;
                r_quot <= {r_quot[FRAC_BITS-1:0], q_bit};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/skin_weight_top4_normalize.sv =====
// top level: keeps the largest bone weights of a vertex and normalizes them
// depends on skw_pkg, skw_cell, skw_div
// throughput: one influence per cycle in S_IDLE; no request taken while computing or draining
// after the last influence each slot passes S_START, S_DIV (serial divider) if kept, and S_OUT,
// waiting there for i_out_ready; an empty slot yields weight 0, a zero sum one result of 1.0
// synchronous active-low reset empties all slots and sets min_weight to 1

module skin_weight_top4_normalize
    import skw_pkg::*;
#(
    parameter int KEEP_COUNT       = DEF_KEEP,
    parameter int WEIGHT_FRAC_BITS = DEF_FRAC
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_req             i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_req            o_out_data,
    input  logic                i_cfg_we,
    input  logic [WEIGHT_W-1:0] i_cfg_data
);

    localparam int SUM_W  = WEIGHT_W + $clog2(KEEP_COUNT + 1);
    localparam int SLOT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int Q_W    = WEIGHT_FRAC_BITS + 1;
    localparam logic [Q_W-1:0] ONE_Q = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [WEIGHT_W-1:0] r_min_weight;
    logic [SUM_W-1:0]    r_sum;
    logic [SLOT_W-1:0]   r_slot_idx;
    logic                r_final;
    logic                r_out_valid;
    t_out_req            r_out;

    t_cell_ctl           cell_ctl;
    t_slot               new_slot;
    t_slot               slots [KEEP_COUNT];
    logic                ins   [KEEP_COUNT];

    logic                accept;
    logic                keep;
    logic                last_slot;
    logic                div_start;
    logic                div_done;
    logic [Q_W-1:0]      div_quot;
    logic [SUM_W-1:0]    drop_w;
    logic [Q_W+WEIGHT_W-1:0] quot_wide;
    logic [Q_W+WEIGHT_W-1:0] one_wide;

    assign accept    = i_in_valid && o_in_ready;
    assign keep      = !i_in_data.no_influence && (i_in_data.joint_weight >= r_min_weight);
    assign last_slot = r_slot_idx == SLOT_W'(KEEP_COUNT - 1);
    assign div_start = (r_state == S_START) && (r_sum != '0) && slots[0].valid;
    assign drop_w    = slots[KEEP_COUNT-1].valid ? SUM_W'(slots[KEEP_COUNT-1].weight) : '0;
    assign quot_wide = {{WEIGHT_W{1'b0}}, div_quot};
    assign one_wide  = {{WEIGHT_W{1'b0}}, ONE_Q};

    assign new_slot.valid  = 1'b1;
    assign new_slot.joint  = i_in_data.joint_index;
    assign new_slot.weight = i_in_data.joint_weight;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        cell_ctl.insert = accept && keep;
        cell_ctl.shift  = 1'b0;
        cell_ctl.clear  = 1'b0;
        if (r_state == S_OUT && i_out_ready) begin
            if (r_final || last_slot) begin
                cell_ctl.clear = 1'b1;
            end else begin
                cell_ctl.shift = 1'b1;
            end
        end
    end

    for (genvar k = 0; k < KEEP_COUNT; k++) begin : g_cell
        t_slot prev_slot;
        t_slot next_slot;
        logic  prev_ins;

        if (k == 0) begin : g_head
            assign prev_slot = '0;
            assign prev_ins  = 1'b0;
        end else begin : g_body
            assign prev_slot = slots[k-1];
            assign prev_ins  = ins[k-1];
        end

        if (k == KEEP_COUNT - 1) begin : g_tail
            assign next_slot = '0;
        end else begin : g_link
            assign next_slot = slots[k+1];
        end

        skw_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_new      (new_slot),
            .i_prev_ins (prev_ins),
            .i_prev     (prev_slot),
            .i_next     (next_slot),
            .o_ins      (ins[k]),
            .o_slot     (slots[k])
        );
    end

    skw_div #(
        .FRAC_BITS (WEIGHT_FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (slots[0].weight),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_weight <= MIN_WEIGHT_RST;
        end else if (i_cfg_we) begin
            r_min_weight <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_slot_idx  <= '0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (keep && ins[KEEP_COUNT-1]) begin
                            r_sum <= r_sum + SUM_W'(i_in_data.joint_weight) - drop_w;
                        end
                        if (i_in_data.last_influence) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    if (r_sum == '0) begin
                        r_out.out_joint   <= '0;
                        r_out.out_weight  <= one_wide[WEIGHT_W-1:0];
                        r_out.last_of_run <= 1'b1;
                        r_final           <= 1'b1;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_OUT;
                    end else if (slots[0].valid) begin
                        r_state <= S_DIV;
                    end else begin
                        r_out.out_joint   <= '0;
                        r_out.out_weight  <= '0;
                        r_out.last_of_run <= last_slot;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out.out_joint   <= slots[0].joint;
                        r_out.out_weight  <= quot_wide[WEIGHT_W-1:0];
                        r_out.last_of_run <= last_slot;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_final || last_slot) begin
                            r_sum      <= '0;
                            r_slot_idx <= '0;
                            r_final    <= 1'b0;
                            r_state    <= S_IDLE;
                        end else begin
                            r_slot_idx <= r_slot_idx + SLOT_W'(1);
                            r_state    <= S_START;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
